// ----- design/csl_pkg.sv -----
// Shared constants, token codes and character-class helpers for the C subset lexer.
// No dependencies; c_subset_lexer refers to it by scoped names.
package csl_pkg;

    // Lexeme length cap: the length output is 8 bits wide.
    localparam int unsigned MAX_LEXEME_LEN = 255;
    localparam logic [7:0]  LEN_CAP = (MAX_LEXEME_LEN < 255) ? 8'(MAX_LEXEME_LEN) : 8'd255;

    localparam int unsigned NUM_KW = 13;

    // Token codes (keywords are 0..NUM_KW-1, taken from the table index).
    localparam logic [5:0] TOK_IDENT  = 6'd13;
    localparam logic [5:0] TOK_INT    = 6'd14;
    localparam logic [5:0] TOK_CHR    = 6'd15;
    localparam logic [5:0] TOK_STR    = 6'd16;
    localparam logic [5:0] TOK_PLUS   = 6'd17;
    localparam logic [5:0] TOK_MINUS  = 6'd18;
    localparam logic [5:0] TOK_STAR   = 6'd19;
    localparam logic [5:0] TOK_SLASH  = 6'd20;
    localparam logic [5:0] TOK_LT     = 6'd21;
    localparam logic [5:0] TOK_LE     = 6'd22;
    localparam logic [5:0] TOK_GT     = 6'd23;
    localparam logic [5:0] TOK_GE     = 6'd24;
    localparam logic [5:0] TOK_EQ     = 6'd25;
    localparam logic [5:0] TOK_NE     = 6'd26;
    localparam logic [5:0] TOK_ASSIGN = 6'd27;
    localparam logic [5:0] TOK_SEMI   = 6'd28;
    localparam logic [5:0] TOK_COMMA  = 6'd29;
    localparam logic [5:0] TOK_LPAREN = 6'd30;
    localparam logic [5:0] TOK_RPAREN = 6'd31;
    localparam logic [5:0] TOK_LBRACK = 6'd32;
    localparam logic [5:0] TOK_RBRACK = 6'd33;
    localparam logic [5:0] TOK_LBRACE = 6'd34;
    localparam logic [5:0] TOK_RBRACE = 6'd35;
    localparam logic [5:0] TOK_ERR    = 6'd36;
    localparam logic [5:0] TOK_NONE   = 6'd63;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    // Keyword text, right-justified in 7 bytes; first letter is the highest used byte.
    localparam logic [55:0] KW_TEXT [NUM_KW] = '{
        56'("const"), 56'("int"), 56'("char"), 56'("void"), 56'("main"),
        56'("if"), 56'("else"), 56'("do"), 56'("while"), 56'("for"),
        56'("scanf"), 56'("printf"), 56'("return")
    };
    localparam int unsigned KW_LEN [NUM_KW] = '{5, 3, 4, 4, 4, 2, 4, 2, 5, 3, 5, 6, 6};

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic logic [5:0] single_code(input logic [7:0] c);
        logic [5:0] code;
        case (c)
            "+":     code = TOK_PLUS;
            "-":     code = TOK_MINUS;
            "*":     code = TOK_STAR;
            "/":     code = TOK_SLASH;
            "<":     code = TOK_LT;
            ">":     code = TOK_GT;
            "=":     code = TOK_ASSIGN;
            ";":     code = TOK_SEMI;
            ",":     code = TOK_COMMA;
            "(":     code = TOK_LPAREN;
            ")":     code = TOK_RPAREN;
            "[":     code = TOK_LBRACK;
            "]":     code = TOK_RBRACK;
            "{":     code = TOK_LBRACE;
            "}":     code = TOK_RBRACE;
            default: code = TOK_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [5:0] double_code(input logic [7:0] c);
        logic [5:0] code;
        case (c)
            "<":     code = TOK_LE;
            ">":     code = TOK_GE;
            "=":     code = TOK_EQ;
            "!":     code = TOK_NE;
            default: code = TOK_NONE;
        endcase
        return code;
    endfunction

    // Drop every keyword whose character at position p is not c.
    function automatic logic [NUM_KW-1:0] kw_filter(input logic [NUM_KW-1:0] hits,
                                                   input logic [7:0] p,
                                                   input logic [7:0] c);
        logic [NUM_KW-1:0] keep;
        keep = '0;
        for (int k = 0; k < NUM_KW; k++) begin
            for (int i = 0; i < 7; i++) begin
                if (i < KW_LEN[k] && p == 8'(i) &&
                    KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8] == c) begin
                    keep[k] = 1'b1;
                end
            end
        end
        return hits & keep;
    endfunction

    // Lowest-numbered keyword that matched the whole lexeme, else identifier.
    function automatic logic [5:0] ident_code(input logic [NUM_KW-1:0] hits,
                                              input logic [7:0] cnt);
        logic [5:0] code;
        code = TOK_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (hits[k] && cnt == 8'(KW_LEN[k])) begin
                code = 6'(k);
            end
        end
        return code;
    endfunction

endpackage

// ----- design/csl_in_if.sv -----
// Source character channel of the lexer: one byte or one end-of-line mark per beat.
// No dependencies.
interface csl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       line_end;

    modport source (output valid, ch, line_end, input ready);
    modport sink   (input valid, ch, line_end, output ready);
endinterface

// ----- design/csl_out_if.sv -----
// Token channel of the lexer: one token code and lexeme length per beat.
// No dependencies.
interface csl_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] token_code;
    logic [7:0] token_length;

    modport source (output valid, token_code, token_length, input ready);
    modport sink   (input valid, token_code, token_length, output ready);
endinterface

// ----- design/c_subset_lexer.sv -----
// Character-serial lexer for a small C subset, top level.
// Depends on csl_pkg, csl_in_if and csl_out_if.
//
// One source byte (or an end-of-line mark) is taken per beat on i_in, and a token beat
// (code plus lexeme length, quotes excluded, saturating at the smaller of MAX_LEXEME_LEN
// and 255) leaves on o_out when a token is known to have ended, using one character of
// lookahead. A beat carries at most one token. The block takes one beat per clock: a
// beat lands in an input register, the scanner state and keyword match vector update from
// it, and the token goes to an output register that drives o_out. Input is only held back
// when the output register is full and not drained. Spaces and unknown bytes are dropped.
// A digit run followed by a letter or '.', or a quote still open at end of line, yields
// an error token (length 0) and the lexer halts; an empty line halts it silently. Once
// halted, beats are taken and discarded until reset.
module c_subset_lexer #(
    parameter int unsigned MAX_LEXEME_LEN = csl_pkg::MAX_LEXEME_LEN
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    csl_in_if.sink          i_in,
    csl_out_if.source       o_out
);

    typedef enum logic [6:0] {
        M_IDLE  = 7'b0000001,
        M_IDENT = 7'b0000010,
        M_NUM   = 7'b0000100,
        M_CHR   = 7'b0001000,
        M_STR   = 7'b0010000,
        M_PUNCT = 7'b0100000,
        M_HALT  = 7'b1000000
    } t_mode;

    localparam int unsigned NK = csl_pkg::NUM_KW;

    // length output is 8 bits wide
    localparam logic [7:0] LEN_CAP = (MAX_LEXEME_LEN < 255) ? 8'(MAX_LEXEME_LEN) : 8'd255;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_ch;
    logic        r_eol;

    // scanner state
    t_mode       r_mode,   n_mode;
    logic [NK-1:0] r_hits, n_hits;
    logic [7:0]  r_count,  n_count;
    logic [7:0]  r_pend,   n_pend;
    logic        r_nonempty, n_nonempty;

    // output register
    logic        r_out_valid;
    logic [5:0]  r_code;
    logic [7:0]  r_len;

    logic        w_adv;
    logic        w_res_valid;
    logic [5:0]  w_res_code;
    logic [7:0]  w_res_len;
    logic [7:0]  w_count_inc;
    logic        w_start;

    // state a fresh token would begin with
    t_mode       s_mode;
    logic [NK-1:0] s_hits;
    logic [7:0]  s_count;
    logic [7:0]  s_pend;

    logic [5:0]  w_single;
    logic [5:0]  w_double;

    assign w_adv       = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_in_valid || w_adv;

    assign w_count_inc = (r_count < LEN_CAP) ? r_count + 8'd1 : r_count;
    assign w_single    = csl_pkg::single_code(r_pend);
    assign w_double    = csl_pkg::double_code(r_pend);

    // token start on the current byte
    always_comb begin
        s_mode  = M_IDLE;
        s_hits  = '0;
        s_count = 8'd0;
        s_pend  = 8'd0;
        if (csl_pkg::is_alpha(r_ch) || r_ch == csl_pkg::CH_UNDER) begin
            s_mode  = M_IDENT;
            s_hits  = csl_pkg::kw_filter({NK{1'b1}}, 8'd0, r_ch);
            s_count = 8'd1;
        end else if (csl_pkg::is_digit(r_ch)) begin
            s_mode  = M_NUM;
            s_count = 8'd1;
        end else if (r_ch == csl_pkg::CH_SQUOTE) begin
            s_mode  = M_CHR;
        end else if (r_ch == csl_pkg::CH_DQUOTE) begin
            s_mode  = M_STR;
        end else if (csl_pkg::single_code(r_ch) != csl_pkg::TOK_NONE ||
                     r_ch == csl_pkg::CH_BANG) begin
            s_mode  = M_PUNCT;
            s_pend  = r_ch;
            s_count = 8'd1;
        end
    end

    // main scan step
    always_comb begin
        n_mode      = r_mode;
        n_hits      = r_hits;
        n_count     = r_count;
        n_pend      = r_pend;
        n_nonempty  = r_nonempty;
        w_res_valid = 1'b0;
        w_res_code  = csl_pkg::TOK_NONE;
        w_res_len   = 8'd0;
        w_start     = 1'b0;

        if (r_mode == M_HALT) begin
            // discard
        end else if (r_eol) begin
            if (!r_nonempty) begin
                n_mode = M_HALT;
            end else begin
                n_nonempty = 1'b0;
                n_mode     = M_IDLE;
                n_count    = 8'd0;
                n_hits     = '0;
                n_pend     = 8'd0;
                case (r_mode)
                    M_IDENT: begin
                        w_res_valid = 1'b1;
                        w_res_code  = csl_pkg::ident_code(r_hits, r_count);
                        w_res_len   = r_count;
                    end
                    M_NUM: begin
                        w_res_valid = 1'b1;
                        w_res_code  = csl_pkg::TOK_INT;
                        w_res_len   = r_count;
                    end
                    M_CHR, M_STR: begin
                        // quote left open
                        w_res_valid = 1'b1;
                        w_res_code  = csl_pkg::TOK_ERR;
                        n_mode      = M_HALT;
                    end
                    M_PUNCT: begin
                        if (w_single != csl_pkg::TOK_NONE) begin
                            w_res_valid = 1'b1;
                            w_res_code  = w_single;
                            w_res_len   = 8'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end else begin
            n_nonempty = 1'b1;
            case (r_mode)
                M_CHR, M_STR: begin
                    if (r_ch == ((r_mode == M_CHR) ? csl_pkg::CH_SQUOTE
                                                   : csl_pkg::CH_DQUOTE)) begin
                        w_res_valid = 1'b1;
                        w_res_code  = (r_mode == M_CHR) ? csl_pkg::TOK_CHR : csl_pkg::TOK_STR;
                        w_res_len   = r_count;
                        n_mode      = M_IDLE;
                        n_count     = 8'd0;
                    end else begin
                        n_count = w_count_inc;
                    end
                end
                M_IDENT: begin
                    if (csl_pkg::is_ident(r_ch)) begin
                        n_hits  = csl_pkg::kw_filter(r_hits, r_count, r_ch);
                        n_count = w_count_inc;
                    end else begin
                        w_res_valid = 1'b1;
                        w_res_code  = csl_pkg::ident_code(r_hits, r_count);
                        w_res_len   = r_count;
                        w_start     = 1'b1;
                    end
                end
                M_NUM: begin
                    if (csl_pkg::is_digit(r_ch)) begin
                        n_count = w_count_inc;
                    end else if (csl_pkg::is_alpha(r_ch) || r_ch == csl_pkg::CH_DOT) begin
                        // malformed number
                        w_res_valid = 1'b1;
                        w_res_code  = csl_pkg::TOK_ERR;
                        n_mode      = M_HALT;
                    end else begin
                        w_res_valid = 1'b1;
                        w_res_code  = csl_pkg::TOK_INT;
                        w_res_len   = r_count;
                        w_start     = 1'b1;
                    end
                end
                M_PUNCT: begin
                    if (r_ch == csl_pkg::CH_EQUAL && w_double != csl_pkg::TOK_NONE) begin
                        w_res_valid = 1'b1;
                        w_res_code  = w_double;
                        w_res_len   = 8'd2;
                        n_mode      = M_IDLE;
                        n_count     = 8'd0;
                        n_pend      = 8'd0;
                    end else begin
                        // lone '!' gives nothing
                        if (w_single != csl_pkg::TOK_NONE) begin
                            w_res_valid = 1'b1;
                            w_res_code  = w_single;
                            w_res_len   = 8'd1;
                        end
                        w_start = 1'b1;
                    end
                end
                default: w_start = 1'b1;
            endcase
            if (w_start) begin
                n_mode  = s_mode;
                n_hits  = s_hits;
                n_count = s_count;
                n_pend  = s_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= M_IDLE;
            r_hits      <= '0;
            r_count     <= 8'd0;
            r_pend      <= 8'd0;
            r_nonempty  <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (r_in_valid && w_adv) begin
                r_mode     <= n_mode;
                r_hits     <= n_hits;
                r_count    <= n_count;
                r_pend     <= n_pend;
                r_nonempty <= n_nonempty;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid && w_res_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_ch  <= i_in.ch;
            r_eol <= i_in.line_end;
        end
        if (w_adv && r_in_valid && w_res_valid) begin
            r_code <= w_res_code;
            r_len  <= w_res_len;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.token_code   = r_code;
    assign o_out.token_length = r_len;

    // once halted, stays halted
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_HALT |=> r_mode == M_HALT)
        else $error("lexer left halt state");

    // halted lexer never raises a new token
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_HALT && !r_out_valid) |=> !r_out_valid)
        else $error("token emitted while halted");

    // error tokens carry no length
    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_code == csl_pkg::TOK_ERR) |-> r_len == 8'd0)
        else $error("error token with nonzero length");

    // length counter saturates at the cap
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_CAP)
        else $error("lexeme count above cap");

    // keyword match vector lives only inside an identifier
    a_hits_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hits != '0 |-> r_mode == M_IDENT)
        else $error("keyword hits outside identifier");

endmodule
